FILE: hdl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i.
// IAU_ASSERT is disabled while rst_ni is low; IAU_ASSERT_ALWAYS also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define IAU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define IAU_ASSERT(lbl, prop)
`define IAU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hdl/iau_pkg.sv
`default_nettype none
package iau_pkg;

  localparam int DefMaxWidth    = 2048;
  localparam int DefMaxChannels = 4;

  localparam int CfgDataW  = 16;
  localparam int CfgIndexW = 2;

  // register indexes
  localparam logic [CfgIndexW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIndexW-1:0] RegImageHeight = 2'd1;
  localparam logic [CfgIndexW-1:0] RegChannels    = 2'd2;

  // reset values
  localparam logic [11:0] RstImageWidth  = 12'd2048;
  localparam logic [15:0] RstImageHeight = 16'd1;
  localparam logic [2:0]  RstChannels    = 3'd4;

  // per-byte control carried into the update stage
  typedef struct packed {
    logic row_first;
    logic col_first;
    logic last;
    logic fwd;
  } s1_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/image_average_unfilter.sv
`default_nettype none
// Average-predictor image unfilter.
// Input channel (in_valid_i / in_stall_o / residual_byte_i): filtered bytes in
// raster order, channel by channel within a pixel. A transaction completes on
// a rising edge with valid high and stall low.
// Output channel (out_valid_o / out_stall_i / pixel_byte_o, last_of_frame_o):
// one reconstructed byte per input transaction, in order; last_of_frame_o
// marks the final byte of the frame.
// Config port (cfg_we_i, cfg_index_i, cfg_data_i): 0 image_width, 1 image_height,
// 2 channels. Any write to a listed register restarts the frame; write only
// while idle.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single read and single write per cycle on the line store. A result passes the
// read stage registers, loaded on the accepting edge, and then the output register.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_stall_o rises in the same cycle; otherwise input is taken every cycle.
// Reset clears counters, valid bits and config to 2048 x 1, 4 channels. The
// line store is not cleared: row zero of every frame writes every entry
// before it is read.
module image_average_unfilter #(
  parameter int MAX_WIDTH    = iau_pkg::DefMaxWidth,
  parameter int MAX_CHANNELS = iau_pkg::DefMaxChannels
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [iau_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [iau_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    residual_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         pixel_byte_o,
  output logic                               last_of_frame_o
);
  import iau_pkg::*;

  `include "assert_macros.svh"

  localparam int Depth = MAX_WIDTH * MAX_CHANNELS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // config registers
  logic [11:0] cfg_width_q;
  logic [15:0] cfg_height_q;
  logic [2:0]  cfg_ch_q;
  logic        cfg_hit;

  // frame position
  logic [ColW-1:0] col_q, col_d;
  logic [15:0]     row_q, row_d;
  logic [ChW-1:0]  ch_q, ch_d;
  logic [ColW-1:0] wlast;
  logic [15:0]     hlast;
  logic [ChW-1:0]  clast;
  logic            last_ch, last_col, last_row;

  // pipeline
  logic            advance, accept;
  logic [AddrW-1:0] raddr;
  logic            s1_valid_q;
  logic [7:0]      s1_res_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [ChW-1:0]  s1_ch_q;
  s1_ctl_t         s1_ctl_q, s1_ctl_d;
  logic [7:0]      fwd_data_q;
  logic [7:0]      rdata_q;
  logic [7:0]      left_q [MAX_CHANNELS];
  logic [7:0]      above, left, pred, pix;
  logic [8:0]      sum;
  logic            out_valid_q;
  logic [7:0]      pixel_q;
  logic            last_q;

  logic [7:0] mem [Depth];

  // ---------------- configuration ----------------
  assign cfg_hit = cfg_we_i && (cfg_index_i == RegImageWidth ||
                                cfg_index_i == RegImageHeight ||
                                cfg_index_i == RegChannels);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RstImageWidth;
      cfg_height_q <= RstImageHeight;
      cfg_ch_q     <= RstChannels;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegImageWidth:  cfg_width_q  <= cfg_data_i[11:0];
        RegImageHeight: cfg_height_q <= cfg_data_i[15:0];
        RegChannels:    cfg_ch_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // last index of each counter; zero acts as one, oversize clamps
  always_comb begin
    if (cfg_width_q == 12'd0) begin
      wlast = '0;
    end else if (17'(cfg_width_q) > 17'(MAX_WIDTH)) begin
      wlast = ColW'(MAX_WIDTH - 1);
    end else begin
      wlast = ColW'(cfg_width_q - 12'd1);
    end
    hlast = (cfg_height_q == 16'd0) ? 16'd0 : cfg_height_q - 16'd1;
    if (cfg_ch_q == 3'd0) begin
      clast = '0;
    end else if (cfg_ch_q > 3'(MAX_CHANNELS)) begin
      clast = ChW'(MAX_CHANNELS - 1);
    end else begin
      clast = ChW'(cfg_ch_q - 3'd1);
    end
  end

  // ---------------- handshake ----------------
  // pipe moves as a whole whenever the output register is empty or drains
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // ---------------- read stage ----------------
  assign last_ch  = (ch_q == clast);
  assign last_col = (col_q == wlast);
  assign last_row = (row_q == hlast);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    ch_d  = ch_q;
    if (!last_ch) begin
      ch_d = ch_q + ChW'(1);
    end else begin
      ch_d = '0;
      if (!last_col) begin
        col_d = col_q + ColW'(1);
      end else begin
        col_d = '0;
        row_d = last_row ? 16'd0 : row_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ch_q  <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
      ch_q  <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      ch_q  <= ch_d;
    end
  end

  assign raddr = AddrW'(int'(col_q) * MAX_CHANNELS + int'(ch_q));

  // Same entry read while the update stage writes it (one-byte rows):
  // take the byte being written instead of the stale memory word.
  always_comb begin
    s1_ctl_d.row_first = (row_q == 16'd0);
    s1_ctl_d.col_first = (col_q == '0);
    s1_ctl_d.last      = last_ch && last_col && last_row;
    s1_ctl_d.fwd       = s1_valid_q && (s1_addr_q == raddr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q   <= residual_byte_i;
      s1_addr_q  <= raddr;
      s1_ch_q    <= ch_q;
      s1_ctl_q   <= s1_ctl_d;
      fwd_data_q <= pix;
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      mem[s1_addr_q] <= pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem[raddr];
    end
  end

  // ---------------- update stage ----------------
  assign above = s1_ctl_q.fwd ? fwd_data_q : rdata_q;
  assign left  = left_q[s1_ch_q];
  assign sum   = {1'b0, left} + {1'b0, above};

  always_comb begin
    priority if (s1_ctl_q.row_first) begin
      pred = s1_ctl_q.col_first ? 8'd0 : left;
    end else if (s1_ctl_q.col_first) begin
      pred = above;
    end else begin
      pred = sum[8:1];
    end
  end

  assign pix = s1_res_q + pred;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      left_q[s1_ch_q] <= pix;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      pixel_q <= pix;
      last_q  <= s1_ctl_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_byte_o    = pixel_q;
  assign last_of_frame_o = last_q;

  // ---------------- assertions ----------------
  // input is held back only while a result waits at the output
  `IAU_ASSERT_ALWAYS(a_stall_needs_result, in_stall_o |-> out_valid_o)
  // counters never leave the configured frame
  `IAU_ASSERT(a_counters_in_range, (col_q <= wlast) && (row_q <= hlast) && (ch_q <= clast))
  // the final byte of a frame wraps the position back to the origin
  `IAU_ASSERT(a_frame_wrap,
              accept && !cfg_hit && s1_ctl_d.last |=> col_q == '0 && row_q == 16'd0 && ch_q == '0)

endmodule
`default_nettype wire
